FILE: design/itp_pkg.sv
// Shared types, constants and character decoders for the infix to postfix converter.
// Depends on nothing; the cell, the stack and the converter import it.
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_CLOSE   = 8'h29;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5,
    OP_LPAR = 3'd6
  } op_code_t;

  typedef enum logic [1:0] {
    SK_HOLD = 2'd0,
    SK_PUSH = 2'd1,
    SK_POP  = 2'd2
  } stack_op_t;

  typedef enum logic [2:0] {
    K_ALNUM = 3'd0,
    K_OPER  = 3'd1,
    K_CLOSE = 3'd2,
    K_EOL   = 3'd3,
    K_OTHER = 3'd4
  } kind_t;

  typedef struct packed {
    stack_op_t op;
    op_code_t  code;
  } stack_cmd_t;

  typedef struct packed {
    op_code_t top;
    op_code_t second;
    logic     empty;
    logic     more;
    logic     full;
  } stack_stat_t;

  function automatic op_code_t classify(input logic [7:0] c);
    op_code_t r;
    unique case (c)
      "+":     r = OP_ADD;
      "-":     r = OP_SUB;
      "*":     r = OP_MUL;
      "/":     r = OP_DIV;
      "^":     r = OP_POW;
      "(":     r = OP_LPAR;
      default: r = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [7:0] op_char(input op_code_t code);
    logic [7:0] r;
    unique case (code)
      OP_ADD:  r = "+";
      OP_SUB:  r = "-";
      OP_MUL:  r = "*";
      OP_DIV:  r = "/";
      OP_POW:  r = "^";
      OP_LPAR: r = "(";
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] op_prec(input op_code_t code);
    logic [1:0] r;
    unique case (code)
      OP_ADD, OP_SUB: r = 2'd1;
      OP_MUL, OP_DIV: r = 2'd2;
      OP_POW:         r = 2'd3;
      default:        r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/itp_in_if.sv
// Input channel of the converter: one character or end-of-line mark per transaction.
// Stands alone; the payload widths are fixed by the character format.
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_line;

  modport source (output valid, output in_char, output end_line, input ready);
  modport sink   (input valid, input in_char, input end_line, output ready);
endinterface

FILE: design/itp_out_if.sv
// Output channel of the converter: one postfix character per transaction.
// Stands alone; the payload widths are fixed by the character format.
interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       overflow;

  modport source (output valid, output out_char, output last, output overflow, input ready);
  modport sink   (input valid, input out_char, input last, input overflow, output ready);
endinterface

FILE: design/itp_cell.sv
// One entry of the operator stack: holds a code and shifts to or from its neighbours.
// Depends on itp_pkg for the stack command and operator code types.
module itp_cell (
  input  logic               clk,
  input  itp_pkg::stack_op_t op,
  input  itp_pkg::op_code_t  from_above,
  input  itp_pkg::op_code_t  from_below,
  output itp_pkg::op_code_t  code
);
  import itp_pkg::*;

  always_ff @(posedge clk) begin
    case (op)
      SK_PUSH: code <= from_above;
      SK_POP:  code <= from_below;
      default: code <= code;
    endcase
  end
endmodule

FILE: design/itp_stack.sv
// Operator stack built as a row of shifting cells with the top in cell zero.
// Depends on itp_pkg and itp_cell; the controller drives it each cycle.
module itp_stack #(
  parameter int DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  itp_pkg::stack_cmd_t  cmd,
  output itp_pkg::stack_stat_t stat
);
  import itp_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  op_code_t      codes [DEPTH];
  logic [CW-1:0] count;
  stack_op_t     cell_op;
  logic          is_full;
  logic          is_empty;

  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);

  always_comb begin
    cell_op = cmd.op;
    if ((cmd.op == SK_PUSH && is_full) || (cmd.op == SK_POP && is_empty)) begin
      cell_op = SK_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    op_code_t above;
    op_code_t below;
    if (i == 0) begin : g_first
      assign above = cmd.code;
    end else begin : g_mid
      assign above = codes[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign below = codes[i];
    end else begin : g_inner
      assign below = codes[i+1];
    end
    itp_cell u_cell (
      .clk        (clk),
      .op         (cell_op),
      .from_above (above),
      .from_below (below),
      .code       (codes[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cell_op == SK_PUSH) begin
      count <= count + 1'b1;
    end else if (cell_op == SK_POP) begin
      count <= count - 1'b1;
    end
  end

  assign stat.top    = codes[0];
  assign stat.second = codes[1];
  assign stat.empty  = is_empty;
  assign stat.more   = (count > CW'(1));
  assign stat.full   = is_full;
endmodule

FILE: design/infix_to_postfix_converter.sv
// Infix to postfix converter (shunting-yard) with an operator stack of shifting cells.
// Depends on itp_pkg, itp_in_if, itp_out_if and itp_stack.
//
// The in_stream channel takes one character, or an end-of-line mark, per transaction.
// The out_stream channel delivers the postfix text one character per transaction;
// last marks the final character caused by an input, overflow reports a dropped push
// since the start of the line. Inputs that cause nothing deliver nothing.
// An input is taken while the sequencer is idle, after which the sequencer delivers one
// character a cycle into the output register while that register is free: a letter or
// digit gives one or two characters, each popped operator two (space and symbol), each
// skipped ( and each push none, and the newline one. The sequencer handles one input at
// a time and takes no new input until it is through with the last one. The output
// register lets a new input be taken while a result still waits. A stalled receiver
// holds the sequencer in place until the register drains.
// Reset empties the stack and clears the operand, line-start and overflow flags.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  itp_in_if.sink   in_stream,
  itp_out_if.source out_stream
);
  import itp_pkg::*;

  typedef enum logic {IDLE, RUN} state_t;

  state_t      state;
  kind_t       kind;
  logic [7:0]  cur_char;
  op_code_t    cur_code;
  logic        sp_done;
  logic        in_operand;
  logic        started;
  logic        line_ovf;

  stack_cmd_t  cmd;
  stack_stat_t stat;

  logic        o_free;
  logic        emit;
  logic [7:0]  emit_char;
  logic        emit_last;
  logic        done;
  logic        sp_next;
  logic        set_ovf;
  logic        accept;
  logic [1:0]  cur_prec;

  itp_stack #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  assign in_stream.ready = (state == IDLE);
  assign accept          = in_stream.valid && in_stream.ready;
  assign o_free          = !out_stream.valid || out_stream.ready;
  assign cur_prec        = op_prec(cur_code);

  always_comb begin
    emit      = 1'b0;
    emit_char = 8'd0;
    emit_last = 1'b0;
    done      = 1'b0;
    sp_next   = sp_done;
    set_ovf   = 1'b0;
    cmd.op    = SK_HOLD;
    cmd.code  = cur_code;
    if (state == RUN) begin
      case (kind)
        K_ALNUM: begin
          if (o_free) begin
            emit = 1'b1;
            if (!in_operand && started && !sp_done) begin
              emit_char = CH_SPACE;
              sp_next   = 1'b1;
            end else begin
              emit_char = cur_char;
              emit_last = 1'b1;
              done      = 1'b1;
            end
          end
        end
        K_EOL: begin
          if (stat.empty) begin
            if (o_free) begin
              emit      = 1'b1;
              emit_char = CH_NEWLINE;
              emit_last = 1'b1;
              done      = 1'b1;
            end
          end else if (stat.top == OP_LPAR) begin
            cmd.op = SK_POP;
          end else if (o_free) begin
            emit = 1'b1;
            if (started && !sp_done) begin
              emit_char = CH_SPACE;
              sp_next   = 1'b1;
            end else begin
              emit_char = op_char(stat.top);
              cmd.op    = SK_POP;
              sp_next   = 1'b0;
            end
          end
        end
        K_CLOSE: begin
          if (stat.empty) begin
            done = 1'b1;
          end else if (stat.top == OP_LPAR) begin
            cmd.op = SK_POP;
            done   = 1'b1;
          end else if (o_free) begin
            emit = 1'b1;
            if (started && !sp_done) begin
              emit_char = CH_SPACE;
              sp_next   = 1'b1;
            end else begin
              emit_char = op_char(stat.top);
              emit_last = !(stat.more && stat.second != OP_LPAR);
              cmd.op    = SK_POP;
              sp_next   = 1'b0;
            end
          end
        end
        K_OPER: begin
          if (cur_code != OP_LPAR && !stat.empty && op_prec(stat.top) >= cur_prec) begin
            if (o_free) begin
              emit = 1'b1;
              if (started && !sp_done) begin
                emit_char = CH_SPACE;
                sp_next   = 1'b1;
              end else begin
                emit_char = op_char(stat.top);
                emit_last = !(stat.more && op_prec(stat.second) >= cur_prec);
                cmd.op    = SK_POP;
                sp_next   = 1'b0;
              end
            end
          end else begin
            done = 1'b1;
            if (stat.full) begin
              set_ovf = 1'b1;
            end else begin
              cmd.op = SK_PUSH;
            end
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= IDLE;
      in_operand       <= 1'b0;
      started          <= 1'b0;
      line_ovf         <= 1'b0;
      sp_done          <= 1'b0;
      out_stream.valid <= 1'b0;
    end else begin
      if (emit) begin
        out_stream.valid    <= 1'b1;
        out_stream.out_char <= emit_char;
        out_stream.last     <= emit_last;
        out_stream.overflow <= line_ovf;
      end else if (out_stream.ready) begin
        out_stream.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            state    <= RUN;
            cur_char <= in_stream.in_char;
            cur_code <= classify(in_stream.in_char);
            sp_done  <= 1'b0;
            if (in_stream.end_line) begin
              kind <= K_EOL;
            end else if (is_alnum(in_stream.in_char)) begin
              kind <= K_ALNUM;
            end else begin
              in_operand <= 1'b0;
              if (in_stream.in_char == CH_CLOSE) begin
                kind <= K_CLOSE;
              end else if (classify(in_stream.in_char) != OP_NONE) begin
                kind <= K_OPER;
              end else begin
                kind <= K_OTHER;
              end
            end
          end
        end
        RUN: begin
          sp_done <= sp_next;
          if (set_ovf) begin
            line_ovf <= 1'b1;
          end
          if (emit && emit_char != CH_SPACE && kind != K_EOL) begin
            started <= 1'b1;
          end
          if (emit && kind == K_EOL && !stat.empty) begin
            started <= 1'b1;
          end
          if (done) begin
            state <= IDLE;
            if (kind == K_ALNUM) begin
              in_operand <= 1'b1;
            end
            if (kind == K_EOL) begin
              in_operand <= 1'b0;
              started    <= 1'b0;
              line_ovf   <= 1'b0;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> o_free)
    else $error("Result produced while the output register was still occupied.");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == SK_PUSH) |-> !stat.full)
    else $error("Push issued onto a full operator stack.");

  a_newline_clears: assert property (@(posedge clk) disable iff (rst)
    (emit && kind == K_EOL && emit_char == CH_NEWLINE) |=> (!started && !line_ovf))
    else $error("Line flags not cleared after the newline.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_stream.ready)
    else $error("Input taken again before the previous one was processed.");
endmodule
